>>> hw/rtl/mtbl_pkg.sv
// ----------------------------------------------------------------------------
// mtbl_pkg
// Shared widths, register indexes and pipeline types of the token bucket limiter
// ----------------------------------------------------------------------------
`default_nettype none

package mtbl_pkg;

   // default configuration of the core
   localparam int unsigned NUM_BUCKETS_DEF = 4;
   localparam int unsigned INTERVAL_MS_DEF = 1000;

   // field widths
   localparam int unsigned BIDX_W     = 2;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned TOK_W      = 16;
   localparam int unsigned PROD_W     = TIME_W + TOK_W;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;

   // register map: rates first, then bursts, one register per bucket
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_BASE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_BASE = 4'd4;

   // per-word context carried down the pipeline
   typedef struct packed {
      logic              active;  // limited class, in-range bucket, non-zero rate
      logic              first;   // bucket never refilled
      logic [BIDX_W-1:0] bucket;
      logic [TOK_W-1:0]  tokens;  // tokens as read, zero for an out-of-range bucket
      logic [TOK_W-1:0]  rate;
      logic [TOK_W-1:0]  burst;
      logic [TIME_W-1:0] now;
   } item_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/mtbl_if.sv
// ----------------------------------------------------------------------------
// mtbl_if
// Valid/ready channels of the token bucket limiter: request, response, csr
// ----------------------------------------------------------------------------
`default_nettype none

interface mtbl_req_if;
   logic                             valid;
   logic                             ready;
   logic [mtbl_pkg::BIDX_W-1:0]      bucket_index;
   logic                             class_known;
   logic [mtbl_pkg::TIME_W-1:0]      now_ms;

   modport source (output valid, output bucket_index, output class_known, output now_ms,
                   input ready);
   modport sink   (input valid, input bucket_index, input class_known, input now_ms,
                   output ready);
endinterface

interface mtbl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             admitted;
   logic [mtbl_pkg::TOK_W-1:0]       tokens_left;

   modport source (output valid, output admitted, output tokens_left, input ready);
   modport sink   (input valid, input admitted, input tokens_left, output ready);
endinterface

interface mtbl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mtbl_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [mtbl_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mtbl_scale.sv
// ----------------------------------------------------------------------------
// mtbl_scale
// Refill scaling stage: elapsed*rate product divided by the interval length,
// by reciprocal multiplication, with a flag for products beyond any bucket cap
// ----------------------------------------------------------------------------
`default_nettype none

module mtbl_scale #(
   parameter int unsigned INTERVAL_MS = mtbl_pkg::INTERVAL_MS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          s1_valid,
   input  wire mtbl_pkg::item_ctl_type        s1_ctl,
   input  wire logic [mtbl_pkg::PROD_W-1:0]   s1_prod,
   output logic                               s2_valid,
   output mtbl_pkg::item_ctl_type             s2_ctl,
   output logic [mtbl_pkg::TOK_W-1:0]         s2_quot,
   output logic                               s2_big
);

   // products at or above this give more tokens than any bucket holds
   localparam logic [63:0] SAT_LIMIT = 64'(INTERVAL_MS) << mtbl_pkg::TOK_W;
   // below the limit the product fits PW bits and the quotient TOK_W bits
   localparam int unsigned PW = $clog2(SAT_LIMIT);
   localparam int unsigned LW = $clog2(INTERVAL_MS);
   localparam int unsigned SH = PW + LW;
   localparam int unsigned MW = PW + 1;
   // rounded-up reciprocal, exact floor for every PW-bit numerator
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(INTERVAL_MS) - 64'd1)
                                   / 64'(INTERVAL_MS);
   localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

   logic                           valid_ff;
   logic                           valid_in;
   mtbl_pkg::item_ctl_type         ctl_ff;
   logic [mtbl_pkg::TOK_W-1:0]     quot_ff;
   logic [mtbl_pkg::TOK_W-1:0]     quot_in;
   logic                           big_ff;
   logic                           big_in;
   logic [PW-1:0]                  prod_low;
   logic [2*PW:0]                  scaled;

   // reciprocal multiply and saturation check
   always_comb begin
      big_in   = (s1_prod >= SAT_LIMIT[mtbl_pkg::PROD_W-1:0]);
      prod_low = s1_prod[PW-1:0];
      scaled   = {{(PW+1){1'b0}}, prod_low} * {{PW{1'b0}}, RECIP_M};
      quot_in  = scaled[SH +: mtbl_pkg::TOK_W];
      valid_in = advance ? s1_valid : valid_ff;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         ctl_ff  <= s1_ctl;
         quot_ff <= quot_in;
         big_ff  <= big_in;
      end
   end

   assign s2_valid = valid_ff;
   assign s2_ctl   = ctl_ff;
   assign s2_quot  = quot_ff;
   assign s2_big   = big_ff;

endmodule

`default_nettype wire

>>> hw/rtl/multi_entry_token_bucket_limiter_core.sv
// ----------------------------------------------------------------------------
// multi_entry_token_bucket_limiter_core
// Per-class token bucket policer with one bucket per request class
// Pipeline: input register, product stage, scaling stage and result register.
// Throughput: one request word per cycle while the response channel takes words and
//   no word shares a bucket with either of the two limited words ahead of it; such a
//   word waits for the write-back.
// Reset: clears rates, bursts, tokens and refill times; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_entry_token_bucket_limiter_core #(
   parameter int unsigned NUM_BUCKETS = mtbl_pkg::NUM_BUCKETS_DEF,
   parameter int unsigned INTERVAL_MS = mtbl_pkg::INTERVAL_MS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mtbl_req_if.sink    req_chan,
   mtbl_rsp_if.source  rsp_chan,
   mtbl_csr_if.sink    csr_chan
);

   localparam int unsigned IW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int unsigned IDXW = mtbl_pkg::CSR_IDX_W;
   localparam int unsigned TW   = mtbl_pkg::TOK_W;
   localparam int unsigned MW   = mtbl_pkg::TIME_W;

   // configuration and bucket state
   logic [TW-1:0]                rate_ff  [NUM_BUCKETS];
   logic [TW-1:0]                burst_ff [NUM_BUCKETS];
   logic [TW-1:0]                tok_ff   [NUM_BUCKETS];
   logic [MW-1:0]                rtime_ff [NUM_BUCKETS];

   // input register
   logic                         s0_valid_ff;
   logic                         s0_valid_in;
   logic [mtbl_pkg::BIDX_W-1:0]  s0_bucket_ff;
   logic                         s0_known_ff;
   logic [MW-1:0]                s0_now_ff;

   // product stage
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   mtbl_pkg::item_ctl_type       s1_ctl_ff;
   mtbl_pkg::item_ctl_type       s1_ctl_in;
   logic [mtbl_pkg::PROD_W-1:0]  s1_prod_ff;
   logic [mtbl_pkg::PROD_W-1:0]  s1_prod_in;

   // scaling stage outputs
   logic                         s2_valid;
   mtbl_pkg::item_ctl_type       s2_ctl;
   logic [TW-1:0]                s2_quot;
   logic                         s2_big;

   // result register
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         out_admit_ff;
   logic                         out_admit_in;
   logic [TW-1:0]                out_tok_ff;
   logic [TW-1:0]                out_tok_in;

   logic                         advance;
   logic                         hazard;
   logic                         s0_go;
   logic                         req_take;
   logic                         csr_take;
   logic                         in_range;
   logic [IW-1:0]                rd_idx;
   logic [IW-1:0]                wr_idx;
   logic [TW-1:0]                rate_rd;
   logic [MW-1:0]                rtime_rd;
   logic [MW-1:0]                elapsed;
   logic [TW:0]                  sum;
   logic                         grow;
   logic                         cap;
   logic [TW-1:0]                base_tok;
   logic                         wr_tok;
   logic                         wr_time;

   // pipeline flow: stall on a full result register or a pending bucket write
   always_comb begin
      advance  = !out_valid_ff || rsp_chan.ready;
      hazard   = s0_valid_ff &&
                 ((s1_valid_ff && s1_ctl_ff.active && (s1_ctl_ff.bucket == s0_bucket_ff)) ||
                  (s2_valid && s2_ctl.active && (s2_ctl.bucket == s0_bucket_ff)));
      s0_go    = s0_valid_ff && !hazard;
      req_take = req_chan.valid && req_chan.ready;
      csr_take = csr_chan.valid && csr_chan.ready;
   end

   assign req_chan.ready = advance && !hazard;
   assign csr_chan.ready = 1'b1;

   // input register valid
   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (advance) begin
         if (req_take) begin
            s0_valid_in = 1'b1;
         end else if (s0_go) begin
            s0_valid_in = 1'b0;
         end
      end
   end

   // state read, elapsed time and refill product
   always_comb begin
      in_range   = (32'(s0_bucket_ff) < NUM_BUCKETS);
      rd_idx     = s0_bucket_ff[IW-1:0];
      rate_rd    = rate_ff[rd_idx];
      rtime_rd   = rtime_ff[rd_idx];
      elapsed    = s0_now_ff - rtime_rd;
      s1_prod_in = mtbl_pkg::PROD_W'(elapsed) * mtbl_pkg::PROD_W'(rate_rd);

      s1_ctl_in.active = in_range && s0_known_ff && (rate_rd != '0);
      s1_ctl_in.first  = (rtime_rd == '0);
      s1_ctl_in.bucket = s0_bucket_ff;
      s1_ctl_in.tokens = in_range ? tok_ff[rd_idx] : '0;
      s1_ctl_in.rate   = rate_rd;
      s1_ctl_in.burst  = burst_ff[rd_idx];
      s1_ctl_in.now    = s0_now_ff;

      s1_valid_in = advance ? s0_go : s1_valid_ff;
   end

   mtbl_scale #(
      .INTERVAL_MS (INTERVAL_MS)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .s1_valid (s1_valid_ff),
      .s1_ctl   (s1_ctl_ff),
      .s1_prod  (s1_prod_ff),
      .s2_valid (s2_valid),
      .s2_ctl   (s2_ctl),
      .s2_quot  (s2_quot),
      .s2_big   (s2_big)
   );

   // refill or first-use load, cap at burst, consume one token on a limited word
   always_comb begin
      wr_idx   = s2_ctl.bucket[IW-1:0];
      sum      = {1'b0, s2_ctl.tokens} + {1'b0, s2_quot};
      grow     = s2_big || (s2_quot != '0);
      cap      = s2_big || (sum > {1'b0, s2_ctl.burst});
      priority if (s2_ctl.first) begin
         base_tok = s2_ctl.rate;
      end else if (grow) begin
         base_tok = cap ? s2_ctl.burst : sum[TW-1:0];
      end else begin
         base_tok = s2_ctl.tokens;
      end

      if (s2_ctl.active) begin
         out_admit_in = (base_tok != '0);
         out_tok_in   = out_admit_in ? (base_tok - TW'(1)) : base_tok;
      end else begin
         out_admit_in = 1'b1;
         out_tok_in   = s2_ctl.tokens;
      end

      wr_tok       = advance && s2_valid && s2_ctl.active;
      wr_time      = wr_tok && (s2_ctl.first || grow);
      out_valid_in = advance ? s2_valid : out_valid_ff;
   end

   // configuration registers and bucket state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            rate_ff[b]  <= '0;
            burst_ff[b] <= '0;
            tok_ff[b]   <= '0;
            rtime_ff[b] <= '0;
         end
      end else begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (csr_take && (csr_chan.reg_index == mtbl_pkg::CSR_RATE_BASE + IDXW'(b))) begin
               rate_ff[b] <= csr_chan.wdata;
            end
            if (csr_take && (csr_chan.reg_index == mtbl_pkg::CSR_BURST_BASE + IDXW'(b))) begin
               burst_ff[b] <= csr_chan.wdata;
            end
         end
         if (wr_tok) begin
            tok_ff[wr_idx] <= out_tok_in;
         end
         if (wr_time) begin
            rtime_ff[wr_idx] <= s2_ctl.now;
         end
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_bucket_ff <= req_chan.bucket_index;
         s0_known_ff  <= req_chan.class_known;
         s0_now_ff    <= req_chan.now_ms;
      end
      if (advance && s0_go) begin
         s1_ctl_ff  <= s1_ctl_in;
         s1_prod_ff <= s1_prod_in;
      end
      if (advance && s2_valid) begin
         out_admit_ff <= out_admit_in;
         out_tok_ff   <= out_tok_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.admitted    = out_admit_ff;
   assign rsp_chan.tokens_left = out_tok_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mtbl_checker.sv
// ----------------------------------------------------------------------------
// mtbl_checker
// Port-level checks on the limiter response channel, bound to the core
// ----------------------------------------------------------------------------
`default_nettype none

module mtbl_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_admitted,
   input wire logic [mtbl_pkg::TOK_W-1:0]  rsp_tokens_left
);

   // nothing comes out of a freshly reset core
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a rejected request means the bucket was empty
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_admitted) |-> (rsp_tokens_left == '0))
      else $error("request rejected with tokens left in the bucket");

   // a stalled response word stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response word dropped while stalled");

   // and keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_admitted) && $stable(rsp_tokens_left)))
      else $error("response payload changed while stalled");

endmodule

bind multi_entry_token_bucket_limiter_core mtbl_checker u_mtbl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_admitted    (rsp_chan.admitted),
   .rsp_tokens_left (rsp_chan.tokens_left)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-entry token bucket limiter core
// A directed table covers reset state, first use, time wrap, saturation at
// the burst cap and ignored register indexes. Random phases with different
// rate and burst settings follow. Every response word is compared with its
// table value or with a behavioural policer kept in step with the accepted request words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import mtbl_pkg::*;

   localparam int unsigned NB              = NUM_BUCKETS_DEF;
   localparam int unsigned INTERVAL        = INTERVAL_MS_DEF;
   localparam int          PHASES          = 6;
   localparam int          ITEMS_PER_PHASE = 113;
   localparam int          HOLD_CYCLES     = 80;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          QUIET_LIMIT     = 1500;

   // register indexes past the last burst register decode to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_BURST_BASE + 4'(NB);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   typedef struct packed {
      logic             admitted;
      logic [TOK_W-1:0] tokens_left;
   } verdict_t;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

   typedef struct packed {
      row_kind_t            kind;
      logic [BIDX_W-1:0]    bucket;
      logic                 known;
      logic [TIME_W-1:0]    now;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0] wdata;
      bit                   typed;
      verdict_t             want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   mtbl_req_if req_chan ();
   mtbl_rsp_if rsp_chan ();
   mtbl_csr_if csr_chan ();

   multi_entry_token_bucket_limiter_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // policer state mirrored on the bench side
   logic [TOK_W-1:0]  rate_cfg  [NB];
   logic [TOK_W-1:0]  burst_cfg [NB];
   logic [TOK_W-1:0]  tok_level [NB];
   logic [TIME_W-1:0] last_fill [NB];
   logic [TOK_W-1:0]  rate_plan [NB];
   logic [TOK_W-1:0]  burst_plan[NB];

   verdict_t  verdict_q[$];
   stim_row_t plan_q[$];

   int  words_sent       = 0;
   int  verdicts_checked = 0;
   int  admits_seen      = 0;
   int  rejects_seen     = 0;
   int  mismatches       = 0;
   int  csr_writes       = 0;
   int  hold_asked       = 0;
   int  hold_done        = 0;
   int  quiet_cycles     = 0;
   bit  idling_on        = 1'b1;
   bit  calm             = 1'b0;

   // one request against the mirrored buckets, updating them as the core would
   function automatic verdict_t police_request(input logic [BIDX_W-1:0] b,
                                               input logic known,
                                               input logic [TIME_W-1:0] now);
      verdict_t          v;
      logic [TOK_W-1:0]  lvl;
      logic [TOK_W-1:0]  rate;
      logic [TOK_W-1:0]  cap;
      logic [TIME_W-1:0] elapsed;
      longint unsigned   gain;
      longint unsigned   sum;
      v.admitted    = 1'b1;
      v.tokens_left = '0;
      if (b >= NB) return v;
      rate = rate_cfg[b];
      cap  = burst_cfg[b];
      lvl  = tok_level[b];
      // unlimited class or zero rate: pass through, report current level
      if (!known || rate == 0) begin
         v.tokens_left = lvl;
         return v;
      end
      if (last_fill[b] == 0) begin
         // first use loads the rate, not capped by burst
         lvl          = rate;
         last_fill[b] = now;
      end else begin
         elapsed = now - last_fill[b];
         gain    = elapsed;
         gain    = gain * rate / INTERVAL;
         if (gain != 0) begin
            sum          = lvl;
            sum          = sum + gain;
            lvl          = (sum > cap) ? cap : sum[TOK_W-1:0];
            last_fill[b] = now;
         end
      end
      if (lvl != 0) lvl = lvl - 1'b1;
      else v.admitted = 1'b0;
      tok_level[b]  = lvl;
      v.tokens_left = lvl;
      return v;
   endfunction

   function automatic void add_req(input logic [BIDX_W-1:0] b, input logic k,
                                   input logic [TIME_W-1:0] now, input bit typed = 1'b0,
                                   input logic adm = 1'b0, input logic [TOK_W-1:0] left = '0);
      stim_row_t r;
      r                  = '0;
      r.kind             = ROW_REQ;
      r.bucket           = b;
      r.known            = k;
      r.now              = now;
      r.typed            = typed;
      r.want.admitted    = adm;
      r.want.tokens_left = left;
      plan_q.push_back(r);
   endfunction

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      stim_row_t r;
      r           = '0;
      r.kind      = ROW_CFG;
      r.reg_index = idx;
      r.wdata     = val;
      plan_q.push_back(r);
   endfunction

   // register write; valid is left high, the caller drops it after the batch
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= val;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx >= CSR_RATE_BASE && idx < CSR_RATE_BASE + NB)
         rate_cfg[idx - CSR_RATE_BASE] = val;
      else if (idx >= CSR_BURST_BASE && idx < CSR_BURST_BASE + NB)
         burst_cfg[idx - CSR_BURST_BASE] = val;
      csr_writes++;
   endtask

   task automatic load_config();
      for (int i = 0; i < NB; i++) write_reg(CSR_RATE_BASE + 4'(i), rate_plan[i]);
      for (int i = 0; i < NB; i++) write_reg(CSR_BURST_BASE + 4'(i), burst_plan[i]);
      // stray write to an undecoded index now and then
      if ($urandom_range(0, 1) == 0)
         write_reg(4'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), 16'($urandom()));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one request word, optionally after a gap; valid stays high afterwards
   task automatic send_request(input logic [BIDX_W-1:0] b, input logic k,
                               input logic [TIME_W-1:0] now, input bit typed,
                               input verdict_t want);
      verdict_t got;
      if (idling_on && !calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.bucket_index <= b;
      req_chan.class_known  <= k;
      req_chan.now_ms       <= now;
      do @(posedge clock); while (!req_chan.ready);
      got = police_request(b, k, now);
      verdict_q.push_back(typed ? want : got);
      words_sent++;
   endtask

   // response side: random stalls, plus a long hold-off on request
   initial begin : rsp_sink
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            hold_done++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (idling_on && !calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each response word with the oldest expected verdict
   always @(posedge clock) begin : rsp_check
      verdict_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: admitted %0d tokens_left %0d",
                        rsp_chan.admitted, rsp_chan.tokens_left);
         end else begin
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (rsp_chan.admitted !== want.admitted ||
                rsp_chan.tokens_left !== want.tokens_left) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected admitted %0d tokens_left %0d, got %0d %0d",
                           verdicts_checked, want.admitted, want.tokens_left,
                           rsp_chan.admitted, rsp_chan.tokens_left);
            end
            if (rsp_chan.admitted === 1'b1) admits_seen++;
            else rejects_seen++;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : main
      stim_row_t         row;
      logic [BIDX_W-1:0] b;
      logic [BIDX_W-1:0] last_b;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] now_t;
      logic              k;
      int                pick;

      req_chan.valid        = 1'b0;
      req_chan.bucket_index = '0;
      req_chan.class_known  = 1'b0;
      req_chan.now_ms       = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.reg_index    = '0;
      csr_chan.wdata        = '0;
      for (int i = 0; i < NB; i++) begin
         rate_cfg[i]  = '0;
         burst_cfg[i] = '0;
         tok_level[i] = '0;
         last_fill[i] = '0;
      end
      last_b = '0;
      now_t  = 32'd5000;

      // directed table
      // reset settings: everything admits with an empty bucket
      add_req(2'd0, 1'b1, 32'd100,        1'b1, 1'b1, 16'd0);
      add_req(2'd3, 1'b0, 32'hFFFF_FFFF,  1'b1, 1'b1, 16'd0);
      add_cfg(CSR_RATE_BASE + 4'd0, 16'd3);
      add_cfg(CSR_RATE_BASE + 4'd1, 16'hFFFF);
      add_cfg(CSR_RATE_BASE + 4'd2, 16'd1);
      add_cfg(CSR_RATE_BASE + 4'd3, 16'd1000);
      add_cfg(CSR_BURST_BASE + 4'd0, 16'd5);
      add_cfg(CSR_BURST_BASE + 4'd1, 16'hFFFF);
      add_cfg(CSR_BURST_BASE + 4'd2, 16'd0);
      add_cfg(CSR_BURST_BASE + 4'd3, 16'd2);
      // first use at time zero keeps the bucket in first-use state
      add_req(2'd0, 1'b1, 32'd0,          1'b1, 1'b1, 16'd2);
      add_req(2'd0, 1'b1, 32'd0,          1'b1, 1'b1, 16'd2);
      add_req(2'd0, 1'b1, 32'd500,        1'b1, 1'b1, 16'd2);
      // drain the bucket, back to back on one entry
      add_req(2'd0, 1'b1, 32'd500);
      add_req(2'd0, 1'b1, 32'd500);
      add_req(2'd0, 1'b1, 32'd500,        1'b1, 1'b0, 16'd0);
      // huge elapsed time saturates at the burst cap
      add_req(2'd0, 1'b1, 32'hFFFF_FFFF,  1'b1, 1'b1, 16'd4);
      // time going backwards across the wrap
      add_req(2'd0, 1'b1, 32'd100);
      add_req(2'd1, 1'b1, 32'd1,          1'b1, 1'b1, 16'hFFFE);
      add_req(2'd1, 1'b1, 32'd0,          1'b1, 1'b1, 16'hFFFE);
      // slow rate with a zero cap
      add_req(2'd2, 1'b1, 32'd7,          1'b1, 1'b1, 16'd0);
      add_req(2'd2, 1'b1, 32'd1006,       1'b1, 1'b0, 16'd0);
      add_req(2'd2, 1'b1, 32'd1007,       1'b1, 1'b0, 16'd0);
      // first use loads the rate above the cap
      add_req(2'd3, 1'b1, 32'd10,         1'b1, 1'b1, 16'd999);
      add_req(2'd3, 1'b1, 32'd11);
      add_req(2'd3, 1'b0, 32'd0);
      add_req(2'd2, 1'b0, 32'hFFFF_FFFF,  1'b1, 1'b1, 16'd0);
      // undecoded indexes must not alias onto real registers
      add_cfg(CSR_RATE_BASE + 4'd0, 16'd0);
      add_cfg(CSR_SPARE_LO, 16'd5);
      add_cfg(CSR_SPARE_HI, 16'd0);
      add_req(2'd0, 1'b1, 32'd2000);
      add_req(2'd3, 1'b1, 32'd12);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < plan_q.size(); r++) begin
         row = plan_q[r];
         if (row.kind == ROW_CFG) begin
            if (r == 0 || plan_q[r-1].kind == ROW_REQ) begin
               req_chan.valid <= 1'b0;
               wait_drained();
            end
            write_reg(row.reg_index, row.wdata);
            if (r + 1 == plan_q.size() || plan_q[r+1].kind == ROW_REQ)
               csr_chan.valid <= 1'b0;
         end else begin
            send_request(row.bucket, row.known, row.now, row.typed, row.want);
         end
      end

      // random phases, each under its own rate and burst setting
      for (int phase = 0; phase < PHASES; phase++) begin
         req_chan.valid <= 1'b0;
         wait_drained();
         pick = $urandom_range(0, NB - 1);
         for (int i = 0; i < NB; i++) begin
            case (phase)
               1: begin
                  rate_plan[i]  = 16'hFFFF;
                  burst_plan[i] = 16'hFFFF;
               end
               2: begin
                  rate_plan[i]  = 16'($urandom_range(1, 20));
                  burst_plan[i] = (i == pick) ? 16'd0 : 16'($urandom_range(1, rate_plan[i]));
               end
               3: begin
                  rate_plan[i]  = (i == pick) ? 16'($urandom_range(1, 200)) : 16'd0;
                  burst_plan[i] = 16'($urandom());
               end
               default: begin
                  case ($urandom_range(0, 5))
                     0:       rate_plan[i] = 16'd0;
                     1:       rate_plan[i] = 16'hFFFF;
                     2, 3:    rate_plan[i] = 16'($urandom_range(1, 50));
                     4:       rate_plan[i] = 16'($urandom_range(50, 5000));
                     default: rate_plan[i] = 16'($urandom());
                  endcase
                  case ($urandom_range(0, 9))
                     0:       burst_plan[i] = 16'd0;
                     1:       burst_plan[i] = 16'hFFFF;
                     2:       burst_plan[i] = 16'($urandom());
                     default: burst_plan[i] = rate_plan[i];
                  endcase
               end
            endcase
         end
         idling_on = (phase != PHASES - 1);
         calm      = 1'b0;
         load_config();

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
            // long receiver hold-off while words keep coming
            if (phase == 1 && n == 10) begin
               calm = 1'b1;
               hold_asked++;
            end
            b = ($urandom_range(0, 2) == 0) ? last_b : 2'($urandom_range(0, NB - 1));
            k = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 19))
               0:       now = $urandom();
               1:       now = '0;
               2:       now = now_t - $urandom_range(1, 500);
               3:       now = now_t + $urandom_range(1000, 200000);
               default: now = now_t + $urandom_range(0, 60);
            endcase
            now_t  = now;
            last_b = b;
            send_request(b, k, now, 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained();

      $display("covered %0d request words under %0d register writes, %0d random phases",
               words_sent, csr_writes, PHASES);
      $display("checked %0d responses: %0d admitted, %0d rejected, %0d mismatches",
               verdicts_checked, admits_seen, rejects_seen, mismatches);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/mtbl_pkg.sv
hw/rtl/mtbl_if.sv
hw/rtl/mtbl_scale.sv
hw/rtl/multi_entry_token_bucket_limiter_core.sv
hw/rtl/mtbl_checker.sv
sim/tb_top.sv
